@@ hdl/linear_key_value_table_macros.svh @@
// Assertion macros shared by the checker of the linear key to value table.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

// Checks that an expression holds at every clock edge out of reset.
`define LKVT_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define LKVT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lkvt_pkg.sv @@
// Shared types and constants of the linear key to value table.
// Used by the top level and by its checker; depends on nothing.
package lkvt_pkg;

	localparam int DEPTH       = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int ENTRY_W     = KEY_WIDTH + VALUE_WIDTH;

	typedef enum logic [1:0] {
		KIND_SET    = 2'd0,
		KIND_GET    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_MOVE = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

@@ hdl/linear_key_value_table.sv @@
// Channel   Direction  Handshake            Word
// request   in         req_valid/req_stall  kind, key, value
// response  out        rsp_valid/rsp_stall  found, read_value, table_full, entries_used
//
// A request goes through scan, move (only for a remove that hits) and done; the scan
// reads the stored entries (at most 16) in turn via the single read port of the memory.
// Reset clears the state machine, the entry count and the response valid; the memory is
// not cleared, as only entries below the count are ever read.
// A stalled response holds; the next request is taken while it waits.
// Top level of the linear key to value table: one entry memory with a scan sequencer.
// Depends on lkvt_pkg.
module linear_key_value_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [1:0]                       kind,
	input  logic [lkvt_pkg::KEY_WIDTH-1:0]   key,
	input  logic [lkvt_pkg::VALUE_WIDTH-1:0] value,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output logic                             found,
	output logic [lkvt_pkg::VALUE_WIDTH-1:0] read_value,
	output logic                             table_full,
	output logic [lkvt_pkg::CNT_W-1:0]       entries_used
);

	lkvt_pkg::state_t state_q;

	logic [lkvt_pkg::ENTRY_W-1:0]     mem [lkvt_pkg::DEPTH];
	logic [lkvt_pkg::ENTRY_W-1:0]     rd_data_s1;
	logic                             pend_s1;
	logic [lkvt_pkg::IDX_W-1:0]       pend_idx_s1;

	lkvt_pkg::kind_t                  kind_q;
	logic [lkvt_pkg::KEY_WIDTH-1:0]   key_q;
	logic [lkvt_pkg::VALUE_WIDTH-1:0] value_q;
	logic [lkvt_pkg::CNT_W-1:0]       count_q;
	logic [lkvt_pkg::CNT_W-1:0]       scan_q;
	logic [lkvt_pkg::IDX_W-1:0]       slot_q;
	logic                             hit_q;
	logic [lkvt_pkg::VALUE_WIDTH-1:0] rdval_q;
	logic                             full_q;

	logic                             match;
	logic                             scan_end;
	logic                             mem_re;
	logic [lkvt_pkg::IDX_W-1:0]       mem_raddr;
	logic                             mem_we;
	logic [lkvt_pkg::IDX_W-1:0]       mem_waddr;
	logic [lkvt_pkg::ENTRY_W-1:0]     mem_wdata;
	logic [lkvt_pkg::CNT_W-1:0]       last_cnt;
	logic                             req_acc;
	logic                             rsp_free;

	assign req_stall = (state_q != lkvt_pkg::ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid || !rsp_stall;
	assign last_cnt  = count_q - lkvt_pkg::CNT_W'(1);

	// The key sits in the upper half of each memory word.
	assign match    = pend_s1 && (rd_data_s1[lkvt_pkg::ENTRY_W-1:lkvt_pkg::VALUE_WIDTH] == key_q);
	assign scan_end = (state_q == lkvt_pkg::ST_SCAN) && (match || (scan_q == count_q));

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = scan_q[lkvt_pkg::IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = pend_idx_s1;
		mem_wdata = {key_q, value_q};
		if (state_q == lkvt_pkg::ST_SCAN) begin
			if (scan_end) begin
				// A remove that hits fetches the last entry to fill the hole.
				if (match && kind_q == lkvt_pkg::KIND_REMOVE) begin
					mem_re    = 1'b1;
					mem_raddr = last_cnt[lkvt_pkg::IDX_W-1:0];
				end
				if (kind_q == lkvt_pkg::KIND_SET) begin
					if (match) begin
						mem_we = 1'b1;
					end else if (count_q != lkvt_pkg::CNT_W'(lkvt_pkg::DEPTH)) begin
						mem_we    = 1'b1;
						mem_waddr = count_q[lkvt_pkg::IDX_W-1:0];
					end
				end
			end else begin
				mem_re = 1'b1;
			end
		end else if (state_q == lkvt_pkg::ST_MOVE) begin
			mem_we    = 1'b1;
			mem_waddr = slot_q;
			mem_wdata = rd_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_raddr];
		end
		pend_idx_s1 <= mem_raddr;
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q  <= lkvt_pkg::kind_t'(kind);
			key_q   <= key;
			value_q <= value;
		end
		if (scan_end) begin
			slot_q  <= pend_idx_s1;
			rdval_q <= (match && kind_q == lkvt_pkg::KIND_GET) ?
				rd_data_s1[lkvt_pkg::VALUE_WIDTH-1:0] : '0;
			full_q  <= !match && kind_q == lkvt_pkg::KIND_SET &&
				count_q == lkvt_pkg::CNT_W'(lkvt_pkg::DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lkvt_pkg::ST_IDLE;
			count_q   <= '0;
			scan_q    <= '0;
			pend_s1   <= 1'b0;
			hit_q     <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			pend_s1 <= mem_re && (state_q == lkvt_pkg::ST_SCAN) && !scan_end;
			// A word taken while the next one is ready is replaced below instead.
			if (rsp_valid && !rsp_stall && state_q != lkvt_pkg::ST_DONE) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				lkvt_pkg::ST_IDLE: begin
					if (req_acc) begin
						scan_q  <= '0;
						state_q <= lkvt_pkg::ST_SCAN;
					end
				end
				lkvt_pkg::ST_SCAN: begin
					if (scan_end) begin
						hit_q <= match;
						if (kind_q == lkvt_pkg::KIND_SET && !match &&
							count_q != lkvt_pkg::CNT_W'(lkvt_pkg::DEPTH)) begin
							count_q <= count_q + lkvt_pkg::CNT_W'(1);
						end
						if (match && kind_q == lkvt_pkg::KIND_REMOVE) begin
							state_q <= lkvt_pkg::ST_MOVE;
						end else begin
							state_q <= lkvt_pkg::ST_DONE;
						end
					end else begin
						scan_q <= scan_q + lkvt_pkg::CNT_W'(1);
					end
				end
				lkvt_pkg::ST_MOVE: begin
					count_q <= last_cnt;
					state_q <= lkvt_pkg::ST_DONE;
				end
				lkvt_pkg::ST_DONE: begin
					if (rsp_free) begin
						rsp_valid <= 1'b1;
						state_q   <= lkvt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lkvt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Response word, loaded only when the output register is free.
	always_ff @(posedge clk) begin
		if (state_q == lkvt_pkg::ST_DONE && rsp_free) begin
			found        <= hit_q && kind_q != lkvt_pkg::KIND_NONE;
			read_value   <= rdval_q;
			table_full   <= full_q;
			entries_used <= count_q;
		end
	end

endmodule

@@ hdl/lkvt_checker.sv @@
// Port-level checker of the linear key to value table, bound to the top level.
// Depends on lkvt_pkg and linear_key_value_table_macros.svh.
`include "linear_key_value_table_macros.svh"

module lkvt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_stall,
	input logic [1:0]                       kind,
	input logic [lkvt_pkg::KEY_WIDTH-1:0]   key,
	input logic [lkvt_pkg::VALUE_WIDTH-1:0] value,
	input logic                             rsp_valid,
	input logic                             rsp_stall,
	input logic                             found,
	input logic [lkvt_pkg::VALUE_WIDTH-1:0] read_value,
	input logic                             table_full,
	input logic [lkvt_pkg::CNT_W-1:0]       entries_used
);

	// A stalled response word must stay put.
	`LKVT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(found) && $stable(read_value) && $stable(entries_used), "stalled response changed")

	`LKVT_ASSERT_ALWAYS(a_count_range, !rsp_valid || entries_used <= lkvt_pkg::CNT_W'(lkvt_pkg::DEPTH), "entry count beyond depth")

	// A dropped set only happens on a new key with the table already full.
	`LKVT_ASSERT_ALWAYS(a_full_sense, !(rsp_valid && table_full) || (!found && entries_used == lkvt_pkg::CNT_W'(lkvt_pkg::DEPTH)), "table full reported with room or a hit")

	`LKVT_ASSERT_ALWAYS(a_value_needs_hit, !(rsp_valid && read_value != '0) || found, "value returned without a hit")

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (.*);
